// File: hw/rtl/pip_pkg.sv
package pip_pkg;

  localparam int MAX_VERTICES_DEF = 64;
  localparam int COORD_BITS_DEF = 32;
  localparam int CORDIC_STEPS_DEF = 24;

  localparam int CW = 64;
  localparam int ZW = 32;
  localparam int DW = ZW + 1;
  localparam int SW = 44;

  localparam logic signed [ZW-1:0] PI_Q = 32'sd843314857;
  localparam logic signed [DW-1:0] TWO_PI_Q = 33'sd1686629714;

  localparam logic [1:0] CFG_THREE_D = 2'd0;
  localparam logic [1:0] CFG_Z_LOW = 2'd1;
  localparam logic [1:0] CFG_Z_HIGH = 2'd2;
  localparam logic [1:0] CFG_VCOUNT = 2'd3;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_RD   = 7'b0000010,
    ST_LOAD = 7'b0000100,
    ST_INIT = 7'b0001000,
    ST_ITER = 7'b0010000,
    ST_ACC  = 7'b0100000,
    ST_DONE = 7'b1000000
  } state_e;

  typedef struct packed {
    logic load_pt;
    logic ld_diff;
    logic init;
    logic iter;
    logic acc;
    logic first;
  } cmd_t;

  function automatic logic [ZW-1:0] atan_q28(input logic [4:0] i);
    logic [ZW-1:0] r;
    case (i)
      5'd0: r = 32'd210828714;
      5'd1: r = 32'd124459457;
      5'd2: r = 32'd65760959;
      5'd3: r = 32'd33381290;
      5'd4: r = 32'd16755422;
      5'd5: r = 32'd8385879;
      5'd6: r = 32'd4193963;
      5'd7: r = 32'd2097109;
      5'd8: r = 32'd1048571;
      5'd9: r = 32'd524287;
      5'd10: r = 32'd262144;
      5'd11: r = 32'd131072;
      5'd12: r = 32'd65536;
      5'd13: r = 32'd32768;
      5'd14: r = 32'd16384;
      5'd15: r = 32'd8192;
      5'd16: r = 32'd4096;
      5'd17: r = 32'd2048;
      5'd18: r = 32'd1024;
      5'd19: r = 32'd512;
      5'd20: r = 32'd256;
      5'd21: r = 32'd128;
      5'd22: r = 32'd64;
      5'd23: r = 32'd32;
      5'd24: r = 32'd16;
      5'd25: r = 32'd8;
      5'd26: r = 32'd4;
      5'd27: r = 32'd2;
      5'd28: r = 32'd1;
      5'd29: r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

// File: hw/rtl/pip_ram.sv
module pip_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// File: hw/rtl/pip_ctrl.sv
module pip_ctrl #(
  parameter int MAX_VERTICES = 64,
  parameter int CORDIC_STEPS = 24
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  input  logic                              req_type_i,
  input  logic                              z_out_i,
  input  logic [$clog2(MAX_VERTICES):0]     n_i,
  output logic                              busy,
  output logic                              res_valid_o,
  output logic [$clog2(MAX_VERTICES)-1:0]   raddr_o,
  output logic [4:0]                        step_o,
  output pip_pkg::cmd_t                     cmd_o
);
  import pip_pkg::*;

  localparam int AW = $clog2(MAX_VERTICES);

  state_e state_q, state_d;
  logic [AW:0] k_q, k_d;
  logic [4:0] step_q, step_d;
  logic accept;

  assign accept = start && (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    k_d = k_q;
    step_d = step_q;
    cmd_o = '0;
    cmd_o.first = (k_q == '0);
    unique case (state_q)
      ST_IDLE: begin
        if (accept && req_type_i) begin
          cmd_o.load_pt = 1'b1;
          k_d = '0;
          state_d = z_out_i ? ST_DONE : ST_RD;
        end
      end
      ST_RD: state_d = ST_LOAD;
      ST_LOAD: begin
        cmd_o.ld_diff = 1'b1;
        state_d = ST_INIT;
      end
      ST_INIT: begin
        cmd_o.init = 1'b1;
        step_d = '0;
        state_d = ST_ITER;
      end
      ST_ITER: begin
        cmd_o.iter = 1'b1;
        step_d = step_q + 5'd1;
        if (step_q == 5'(CORDIC_STEPS - 1)) begin
          state_d = ST_ACC;
        end
      end
      ST_ACC: begin
        cmd_o.acc = 1'b1;
        k_d = k_q + 1'b1;
        state_d = (k_q == n_i) ? ST_DONE : ST_RD;
      end
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q <= '0;
      step_q <= '0;
    end else begin
      state_q <= state_d;
      k_q <= k_d;
      step_q <= step_d;
    end
  end

  assign busy = (state_q != ST_IDLE);
  assign res_valid_o = (state_q == ST_DONE);
  assign raddr_o = (k_q == n_i) ? '0 : k_q[AW-1:0];
  assign step_o = step_q;
endmodule

// File: hw/rtl/pip_dp.sv
module pip_dp #(
  parameter int MAX_VERTICES = 64,
  parameter int COORD_BITS = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [1:0]                       cfg_idx_i,
  input  logic [COORD_BITS-1:0]            cfg_wdata_i,
  input  logic signed [COORD_BITS-1:0]     coord_x_i,
  input  logic signed [COORD_BITS-1:0]     coord_y_i,
  input  logic signed [COORD_BITS-1:0]     coord_z_i,
  input  logic [2*COORD_BITS-1:0]          vert_i,
  input  logic [4:0]                       step_i,
  input  pip_pkg::cmd_t                    cmd_i,
  output logic                             z_out_o,
  output logic [$clog2(MAX_VERTICES):0]    n_o,
  output logic                             inside_res_o
);
  import pip_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int PRESHIFT = 59 - COORD_BITS;
  localparam int AW = $clog2(MAX_VERTICES);
  localparam int PW = 2 * CB + 2;

  logic three_d_q;
  logic signed [CB-1:0] z_low_q, z_high_q;
  logic [6:0] vcount_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      three_d_q <= 1'b0;
      z_low_q <= '0;
      z_high_q <= '0;
      vcount_q <= 7'd3;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_THREE_D: three_d_q <= cfg_wdata_i[0];
        CFG_Z_LOW: z_low_q <= cfg_wdata_i;
        CFG_Z_HIGH: z_high_q <= cfg_wdata_i;
        CFG_VCOUNT: vcount_q <= cfg_wdata_i[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (int'(vcount_q) < 3) n_o = (AW+1)'(3);
    else if (int'(vcount_q) > MAX_VERTICES) n_o = (AW+1)'(MAX_VERTICES);
    else n_o = (AW+1)'(vcount_q);
  end

  assign z_out_o = three_d_q && ((coord_z_i < z_low_q) || (coord_z_i > z_high_q));

  logic signed [CB-1:0] px_q, py_q;
  logic reject_q;
  logic signed [CB:0] cx_q, cy_q, sx_q, sy_q, cur_x, cur_y;
  logic signed [PW-1:0] p1_q, p2_q;
  logic cpos_q;
  logic signed [CW-1:0] x_q, y_q, x_d, y_d, x0, y0;
  logic signed [ZW-1:0] z_q, z_d, ang_prev_q;
  logic zero_cur_q, zero_prev_q;
  logic signed [SW-1:0] sum_q, sum_abs;
  logic signed [DW-1:0] d_raw, d_wrap, d_abs;
  logic signed [PW:0] cdiff;
  logic signed [ZW-1:0] at;

  assign cur_x = $signed({vert_i[CB-1], vert_i[CB-1:0]}) - $signed({px_q[CB-1], px_q});
  assign cur_y = $signed({vert_i[2*CB-1], vert_i[2*CB-1:CB]}) - $signed({py_q[CB-1], py_q});
  assign x0 = CW'(cx_q);
  assign y0 = CW'(cy_q);
  assign at = $signed(atan_q28(step_i));
  assign cdiff = $signed({p1_q[PW-1], p1_q}) - $signed({p2_q[PW-1], p2_q});

  always_comb begin
    x_d = x_q;
    y_d = y_q;
    z_d = z_q;
    if (cmd_i.init) begin
      if (cx_q < 0) begin
        z_d = (cy_q < 0) ? -PI_Q : PI_Q;
        x_d = (-x0) <<< PRESHIFT;
        y_d = (-y0) <<< PRESHIFT;
      end else begin
        z_d = '0;
        x_d = x0 <<< PRESHIFT;
        y_d = y0 <<< PRESHIFT;
      end
    end else if (cmd_i.iter) begin
      if (y_q < 0) begin
        x_d = x_q - (y_q >>> step_i);
        y_d = y_q + (x_q >>> step_i);
        z_d = z_q - at;
      end else begin
        x_d = x_q + (y_q >>> step_i);
        y_d = y_q - (x_q >>> step_i);
        z_d = z_q + at;
      end
    end
  end

  always_comb begin
    d_raw = DW'(z_q) - DW'(ang_prev_q);
    if (d_raw > DW'(PI_Q)) d_wrap = d_raw - TWO_PI_Q;
    else if (d_raw < -DW'(PI_Q)) d_wrap = d_raw + TWO_PI_Q;
    else d_wrap = d_raw;
    d_abs = (zero_cur_q || zero_prev_q) ? '0 : ((d_wrap < 0) ? -d_wrap : d_wrap);
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
    if (cmd_i.load_pt) begin
      px_q <= coord_x_i;
      py_q <= coord_y_i;
      reject_q <= z_out_o;
      sum_q <= '0;
    end
    if (cmd_i.ld_diff) begin
      cx_q <= cur_x;
      cy_q <= cur_y;
    end
    if (cmd_i.init) begin
      p1_q <= PW'(cx_q) * PW'(sy_q);
      p2_q <= PW'(cy_q) * PW'(sx_q);
      zero_cur_q <= (cx_q == 0) && (cy_q == 0);
    end
    if (cmd_i.iter) begin
      cpos_q <= (cdiff > 0);
    end
    if (cmd_i.acc) begin
      if (!cmd_i.first) begin
        sum_q <= cpos_q ? sum_q + SW'(d_abs) : sum_q - SW'(d_abs);
      end
      ang_prev_q <= z_q;
      zero_prev_q <= zero_cur_q;
      sx_q <= cx_q;
      sy_q <= cy_q;
    end
  end

  assign sum_abs = (sum_q < 0) ? -sum_q : sum_q;
  assign inside_res_o = !reject_q && (sum_abs >= SW'(PI_Q));
endmodule

// File: hw/rtl/point_in_polygon_angle_sum_core.sv
// point in polygon test by angle summation
// request channel: start/busy; a request is taken at a clock edge with start
// high and busy low. req_type_i 0 writes vertex (coord_x_i, coord_y_i) into
// slot vertex_index_i and gives no result; slots at or beyond
// the table depth are dropped.
// req_type_i 1 tests point (coord_x_i, coord_y_i, coord_z_i) and gives one
// result: res_valid_o is high for one cycle with inside_res_o.
// a query rejected by the z range in 3d mode answers in the cycle after accept.
// otherwise the query visits n+1 vertices (n = vertex_count clamped to
// 3..MAX_VERTICES), each through the table read, the difference load, the
// init and the iterations of the shared iterative cordic, and the accumulate;
// one request is worked on at a time, busy stays high meanwhile.
// configuration: cfg_we_i, cfg_idx_i, cfg_wdata_i, written only while idle by
// the user; the block does not enforce it. reset clears control and
// configuration (vertex_count 3); the vertex table holds no reset value and
// must be written before use. results cannot be stalled by the receiver.
module point_in_polygon_angle_sum_core #(
  parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF,
  parameter int COORD_BITS = pip_pkg::COORD_BITS_DEF,
  parameter int CORDIC_STEPS = pip_pkg::CORDIC_STEPS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_idx_i,
  input  logic [COORD_BITS-1:0]        cfg_wdata_i,
  input  logic                         start,
  output logic                         busy,
  input  logic                         req_type_i,
  input  logic [5:0]                   vertex_index_i,
  input  logic signed [COORD_BITS-1:0] coord_x_i,
  input  logic signed [COORD_BITS-1:0] coord_y_i,
  input  logic signed [COORD_BITS-1:0] coord_z_i,
  output logic                         res_valid_o,
  output logic                         inside_res_o
);
  import pip_pkg::*;

  localparam int AW = $clog2(MAX_VERTICES);

  cmd_t cmd;
  logic z_out, we;
  logic [AW:0] n;
  logic [AW-1:0] raddr;
  logic [4:0] step;
  logic [2*COORD_BITS-1:0] vert;

  assign we = start && !busy && !req_type_i && (int'(vertex_index_i) < MAX_VERTICES);

  pip_ram #(.WIDTH(2 * COORD_BITS), .DEPTH(MAX_VERTICES)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (AW'(vertex_index_i)),
    .wdata_i ({coord_y_i, coord_x_i}),
    .raddr_i (raddr),
    .rdata_o (vert)
  );

  pip_ctrl #(.MAX_VERTICES(MAX_VERTICES), .CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .req_type_i  (req_type_i),
    .z_out_i     (z_out),
    .n_i         (n),
    .busy        (busy),
    .res_valid_o (res_valid_o),
    .raddr_o     (raddr),
    .step_o      (step),
    .cmd_o       (cmd)
  );

  pip_dp #(.MAX_VERTICES(MAX_VERTICES), .COORD_BITS(COORD_BITS)) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .coord_x_i    (coord_x_i),
    .coord_y_i    (coord_y_i),
    .coord_z_i    (coord_z_i),
    .vert_i       (vert),
    .step_i       (step),
    .cmd_i        (cmd),
    .z_out_o      (z_out),
    .n_o          (n),
    .inside_res_o (inside_res_o)
  );
endmodule

// File: dv/point_in_polygon_angle_sum_core_tb.sv
`timescale 1ns / 1ps

module point_in_polygon_angle_sum_core_tb;
  import pip_pkg::*;

  localparam int LIMIT_CYCLES = 1500000;
  localparam int TAIL_CYCLES = 2000;
  localparam logic signed [63:0] PI_V = 64'sd843314857;
  localparam logic signed [63:0] TWO_PI_V = 64'sd1686629714;
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam logic [31:0] ATAN_TAB [24] = '{
    32'd210828714, 32'd124459457, 32'd65760959, 32'd33381290, 32'd16755422,
    32'd8385879, 32'd4193963, 32'd2097109, 32'd1048571, 32'd524287,
    32'd262144, 32'd131072, 32'd65536, 32'd32768, 32'd16384, 32'd8192,
    32'd4096, 32'd2048, 32'd1024, 32'd512, 32'd256, 32'd128, 32'd64, 32'd32
  };

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [31:0] cfg_wdata_i;
  logic start;
  logic busy;
  logic req_type_i;
  logic [5:0] vertex_index_i;
  logic signed [31:0] coord_x_i, coord_y_i, coord_z_i;
  logic res_valid_o;
  logic inside_res_o;

  point_in_polygon_angle_sum_core dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i, .start, .busy,
    .req_type_i, .vertex_index_i, .coord_x_i, .coord_y_i, .coord_z_i,
    .res_valid_o, .inside_res_o
  );

  always #4 clk_i = ~clk_i;

  // model of the block
  logic m_three_d;
  logic signed [31:0] m_z_low, m_z_high;
  logic [6:0] m_vcount;
  logic signed [31:0] m_vx [64];
  logic signed [31:0] m_vy [64];

  logic inside_exp_q [$];
  int errors = 0;
  int n_results = 0;
  int n_queries = 0;
  int n_writes = 0;
  int cycles = 0;
  int gap_pct = 0;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      n_results++;
      if (inside_exp_q.size() == 0) begin
        report_mismatch("result with no request pending");
      end else begin
        logic e;
        e = inside_exp_q.pop_front();
        if (inside_res_o !== e)
          report_mismatch($sformatf("inside_res got %b want %b", inside_res_o, e));
      end
    end
  end

  function automatic logic signed [63:0] vec_ang(input logic signed [63:0] x0,
                                                 input logic signed [63:0] y0);
    logic signed [63:0] x, y, z, dx, dy;
    logic yneg;
    x = x0;
    y = y0;
    z = 0;
    if (x < 0) begin
      z = (y < 0) ? -PI_V : PI_V;
      x = -x;
      y = -y;
    end
    x = x <<< 27;
    y = y <<< 27;
    for (int i = 0; i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      yneg = y < 0;
      if (yneg) begin
        x = x - dx;
        y = y + dy;
        z = z - $signed({32'd0, ATAN_TAB[i]});
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + $signed({32'd0, ATAN_TAB[i]});
      end
    end
    return z;
  endfunction

  function automatic logic predict_inside(input logic signed [31:0] px,
                                          input logic signed [31:0] py,
                                          input logic signed [31:0] pz);
    logic signed [63:0] sx, sy, ex, ey, d, sum;
    logic signed [69:0] cr;
    int n, j;
    if (m_three_d && (pz < m_z_low || pz > m_z_high)) return 1'b0;
    n = m_vcount;
    if (n < 3) n = 3;
    if (n > 64) n = 64;
    sum = 0;
    for (int i = 0; i < n; i++) begin
      j = (i + 1 == n) ? 0 : i + 1;
      sx = 64'(m_vx[i]) - 64'(px);
      sy = 64'(m_vy[i]) - 64'(py);
      ex = 64'(m_vx[j]) - 64'(px);
      ey = 64'(m_vy[j]) - 64'(py);
      if ((sx == 0 && sy == 0) || (ex == 0 && ey == 0)) begin
        d = 0;
      end else begin
        d = vec_ang(ex, ey) - vec_ang(sx, sy);
        if (d > PI_V) d = d - TWO_PI_V;
        else if (d < -PI_V) d = d + TWO_PI_V;
        if (d < 0) d = -d;
      end
      cr = 70'(ex) * 70'(sy) - 70'(ey) * 70'(sx);
      if (cr > 0) sum = sum + d;
      else sum = sum - d;
    end
    if (sum < 0) sum = -sum;
    return sum >= PI_V;
  endfunction

  task automatic wait_drained();
    start <= 1'b0;
    wait (inside_exp_q.size() == 0);
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
    wait_drained();
    repeat (4) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_THREE_D: m_three_d = val[0];
      CFG_Z_LOW:   m_z_low = val;
      CFG_Z_HIGH:  m_z_high = val;
      CFG_VCOUNT:  m_vcount = val[6:0];
      default: ;
    endcase
  endtask

  task automatic send_req(input logic rt, input logic [5:0] idx, input logic signed [31:0] x,
                          input logic signed [31:0] y, input logic signed [31:0] z);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    req_type_i <= rt;
    vertex_index_i <= idx;
    coord_x_i <= x;
    coord_y_i <= y;
    coord_z_i <= z;
    do @(posedge clk_i); while (busy);
    if (rt == REQ_WRITE) begin
      m_vx[idx] = x;
      m_vy[idx] = y;
      n_writes++;
    end else begin
      inside_exp_q.push_back(predict_inside(x, y, z));
      n_queries++;
    end
  endtask

  task automatic write_vertex(input int idx, input logic signed [31:0] x,
                              input logic signed [31:0] y);
    send_req(REQ_WRITE, 6'(idx), x, y, 32'($urandom));
  endtask

  task automatic query(input logic signed [31:0] x, input logic signed [31:0] y,
                       input logic signed [31:0] z);
    send_req(REQ_QUERY, 6'($urandom), x, y, z);
  endtask

  task automatic test_directed();
    gap_pct = 0;
    write_vertex(0, 32'sh0000_0000, 32'sh0000_0000);
    write_vertex(1, 32'sh000a_0000, 32'sh0000_0000);
    write_vertex(2, 32'sh0000_0000, 32'sh000a_0000);
    query(32'sh0002_0000, 32'sh0002_0000, 0);
    query(32'sh0010_0000, 32'sh0010_0000, 0);
    // point on a vertex
    query(32'sh000a_0000, 32'sh0000_0000, 0);
    // point on an edge line
    query(32'sh0005_0000, 32'sh0000_0000, 0);
    query(32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000);
    cfg_write(CFG_THREE_D, 32'd1);
    cfg_write(CFG_Z_LOW, 32'hffff_ff9c);
    cfg_write(CFG_Z_HIGH, 32'd100);
    query(32'sh0002_0000, 32'sh0002_0000, 32'sd100);
    query(32'sh0002_0000, 32'sh0002_0000, -32'sd101);
    query(32'sh0002_0000, 32'sh0002_0000, 32'sh7fff_ffff);
    // inverted z range
    cfg_write(CFG_Z_LOW, 32'h7fff_ffff);
    cfg_write(CFG_Z_HIGH, 32'h8000_0000);
    query(32'sh0002_0000, 32'sh0002_0000, 0);
    cfg_write(CFG_Z_LOW, 32'h8000_0000);
    cfg_write(CFG_Z_HIGH, 32'h7fff_ffff);
    query(32'sh0002_0000, 32'sh0002_0000, 32'sh8000_0000);
    cfg_write(CFG_THREE_D, 32'd0);
    // vertex_count below range saturates
    cfg_write(CFG_VCOUNT, 32'd1);
    write_vertex(0, 32'sh8000_0000, 32'sh8000_0000);
    write_vertex(1, 32'sh7fff_ffff, 32'sh8000_0000);
    write_vertex(2, 32'sh0000_0000, 32'sh7fff_ffff);
    query(0, 0, 0);
    query(32'sh7fff_ffff, 32'sh7fff_ffff, 0);
    query(32'sh8000_0000, 32'sh8000_0000, 0);
    query(32'sh8000_0000, 32'sh7fff_ffff, 0);
    cfg_write(CFG_VCOUNT, 32'd0);
    query(32'sh0000_0001, 32'sh8000_0001, 0);
  endtask

  task automatic load_polygon(input int n, output int cx, output int cy, output int r);
    real a;
    cx = $signed($urandom_range(32'h2000_0000)) - 32'sh1000_0000;
    cy = $signed($urandom_range(32'h2000_0000)) - 32'sh1000_0000;
    r = $urandom_range(32'h0400_0000, 32'h0001_0000);
    for (int i = 0; i < n; i++) begin
      a = 6.283185307 * (i + ($urandom_range(800) / 1000.0)) / n;
      if ($urandom_range(3) == 0) a = -a;
      write_vertex(i, cx + $rtoi(r * $cos(a) * ($urandom_range(100, 40) / 100.0)),
                   cy + $rtoi(r * $sin(a) * ($urandom_range(100, 40) / 100.0)));
    end
  endtask

  task automatic test_random_phase(input int n, input logic [31:0] vc_val, input int items,
                                   input int pct, input bit pause);
    int cx, cy, r, k;
    gap_pct = 0;
    cfg_write(CFG_VCOUNT, vc_val);
    if ($urandom_range(1)) begin
      cfg_write(CFG_THREE_D, 32'd1);
      cfg_write(CFG_Z_LOW, $urandom_range(32'h7fff_ffff) - 32'h4000_0000);
      cfg_write(CFG_Z_HIGH, $urandom);
    end else begin
      cfg_write(CFG_THREE_D, 32'd0);
    end
    gap_pct = pct;
    load_polygon(n, cx, cy, r);
    for (int i = 0; i < items; i++) begin
      if (pause && i == items / 2) begin
        wait_drained();
      end
      k = $urandom_range(99);
      if (k < 75) begin
        query(cx + $signed($urandom_range(3 * r)) - (3 * r) / 2,
              cy + $signed($urandom_range(3 * r)) - (3 * r) / 2, $urandom);
      end else if (k < 85) begin
        query($urandom, $urandom, $urandom);
      end else if (k < 92) begin
        // a query right on a vertex
        k = $urandom_range(n - 1);
        query(m_vx[k], m_vy[k], $urandom);
      end else begin
        k = $urandom_range(63);
        if (k < n) k = n + $urandom_range(63 - n);
        if (k > 63) k = 63;
        if (n < 64) write_vertex(k, $urandom, $urandom);
        else query($urandom, $urandom, $urandom);
      end
    end
  endtask

  task automatic test_random();
    int pcts [4] = '{0, 83, 7, 0};
    for (int p = 0; p < 5; p++)
      test_random_phase($urandom_range(8, 3), 0, 52, pcts[p % 4], p == 4);
    test_random_phase(3, 32'd3, 40, 83, 1'b0);
    // above range saturates to the full table
    test_random_phase(64, 32'h0000_007f, 12, 7, 1'b0);
    test_random_phase(64, 32'd64, 10, 0, 1'b0);
    test_random_phase(63, 32'd63, 8, 83, 1'b0);
  endtask

  initial begin
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= '0;
    cfg_wdata_i <= '0;
    start <= 1'b0;
    req_type_i <= REQ_WRITE;
    vertex_index_i <= '0;
    coord_x_i <= '0;
    coord_y_i <= '0;
    coord_z_i <= '0;
    m_three_d = 1'b0;
    m_z_low = 0;
    m_z_high = 0;
    m_vcount = 7'd3;
    foreach (m_vx[i]) begin
      m_vx[i] = 0;
      m_vy[i] = 0;
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (inside_exp_q.size() != 0) report_mismatch("results still pending at end");
    $display("covered %0d vertex writes and %0d point queries, %0d results checked",
             n_writes, n_queries, n_results);
    $display("2d and 3d modes, inverted z ranges, vertex counts 3 to 64, idle mixes");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/pip_pkg.sv
hw/rtl/pip_ram.sv
hw/rtl/pip_ctrl.sv
hw/rtl/pip_dp.sv
hw/rtl/point_in_polygon_angle_sum_core.sv
dv/point_in_polygon_angle_sum_core_tb.sv
